// File: rtl/core/sdblk_pkg.sv
// Package for the SD-card SPI-mode block transfer engine.
// Holds phase codes, status codes, field widths and the command byte helper.
// No dependencies.
`default_nettype none
package sdblk_pkg;

  localparam int unsigned BlockBytes  = 512;
  localparam int unsigned R1PollLimit = 8;
  localparam int unsigned PollW       = 17;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InDataW     = 72;
  localparam int unsigned OutDataW    = 24;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD, PH_R1, PH_RTOK, PH_RDATA, PH_RCRC, PH_RTRAIL,
    PH_SCMD, PH_SSTUFF, PH_SR1, PH_SBUSY_OK, PH_SBUSY_BAD,
    PH_WTOK, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY, PH_WSTOP, PH_WSTOPBUSY
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK, ST_RANGE, ST_R1_TIMEOUT, ST_R1_ERROR, ST_TOKEN_TIMEOUT, ST_TRAILER,
    ST_RESP_TIMEOUT, ST_CRC_REJECT, ST_WRITE_REJECT, ST_BUSY_TIMEOUT, ST_STOP_ERROR
  } status_e;

  typedef enum logic [1:0] {
    OP_READ_ONE, OP_READ_MANY, OP_WRITE_ONE, OP_WRITE_MANY
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_CAP, CFG_TOTAL_BLOCKS, CFG_SINGLE_TOK, CFG_MULTI_TOK, CFG_BUSY_WAIT,
    CFG_UNUSED5, CFG_UNUSED6, CFG_UNUSED7
  } cfg_e;

  localparam logic [7:0] TokSingle = 8'hFE;
  localparam logic [7:0] TokMulti  = 8'hFC;
  localparam logic [7:0] TokStop   = 8'hFD;
  localparam logic [7:0] IdleByte  = 8'hFF;
  localparam logic [5:0] CmdStop   = 6'd12;

  function automatic logic [5:0] op_cmd(input logic [1:0] op);
    logic [5:0] r;
    case (op)
      OP_READ_ONE:  r = 6'd17;
      OP_READ_MANY: r = 6'd18;
      OP_WRITE_ONE: r = 6'd24;
      default:      r = 6'd25;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [31:0] arg,
                                            input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = {2'b01, idx};
      3'd1:    r = arg[31:24];
      3'd2:    r = arg[23:16];
      3'd3:    r = arg[15:8];
      3'd4:    r = arg[7:0];
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sd_spi_block_transfer_engine_top.sv
// Top level of the SD-card SPI-mode block transfer engine.
// Depends on sdblk_pkg.
//
// channel | dir | contents
// s_axis  | in  | one word per start request or completed SPI byte slot
// m_axis  | out | one result word per input word
// cfg     | in  | register writes, index 0..4
//
// The sequencer state and the result register update together at the
// accept edge, so one word per cycle is taken while the output is not
// stalled. The result register is a single stage; the input is ready when
// it is empty or being drained in the same cycle. Reset puts the sequencer
// in idle, control registers at defaults; a stalled output holds its word.
`default_nettype none
module sd_spi_block_transfer_engine_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: op[1:0], block_number[31:0], block_count[15:0],
  //        miso_byte[7:0], write_byte[7:0], zero fill
  input  wire logic [sdblk_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: cmd (0 start, 1 byte slot completed)
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: mosi_byte[7:0], chip_select_active, read_valid, read_byte[7:0],
  //        write_taken, done_res, status[3:0]
  output logic [sdblk_pkg::OutDataW-1:0]      m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [sdblk_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sdblk_pkg::CfgDataW-1:0] cfg_data_i
);
  import sdblk_pkg::*;

  logic        hc_q;
  logic [31:0] total_q;
  logic [PollW-1:0] stok_q, mtok_q, bwait_q;

  phase_e      phase_q, phase_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [PollW-1:0] poll_q, poll_d;
  logic [15:0] left_q, left_d;
  logic [31:0] addr_q, addr_d;
  logic [1:0]  oper_q, oper_d;

  logic        out_valid_q;
  logic [OutDataW-1:0] out_q;

  logic        in_cmd;
  logic [1:0]  in_op;
  logic [31:0] in_bn;
  logic [15:0] in_bc;
  logic [7:0]  m, w;

  logic [7:0]  mosi;
  logic        cs, rv, wt, done;
  logic [7:0]  rb;
  status_e     st;
  logic        accept;
  logic [PollW-1:0] poll_inc;
  logic [PollW-1:0] lim;
  logic        miss;
  logic [32:0] end_blk;
  logic        bad;
  logic [31:0] new_addr;
  logic [2:0]  bi;

  assign in_cmd = s_axis_tuser;
  assign in_op  = s_axis_tdata[1:0];
  assign in_bn  = s_axis_tdata[33:2];
  assign in_bc  = s_axis_tdata[49:34];
  assign m      = s_axis_tdata[57:50];
  assign w      = s_axis_tdata[65:58];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign poll_inc = poll_q + PollW'(1);
  assign end_blk  = {1'b0, in_bn} + {17'd0, in_bc};
  assign new_addr = hc_q ? in_bn : {in_bn[22:0], 9'd0};

  // A limit of zero acts as one, which the >= compare already gives.
  always_comb begin
    case (phase_q)
      PH_RTOK:      lim = (oper_q == OP_READ_ONE) ? stok_q : mtok_q;
      PH_SBUSY_OK, PH_SBUSY_BAD, PH_WBUSY, PH_WSTOPBUSY: lim = bwait_q;
      default:      lim = PollW'(R1PollLimit);
    endcase
    miss = poll_inc >= lim;
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    poll_d  = poll_q;
    left_d  = left_q;
    addr_d  = addr_q;
    oper_d  = oper_q;
    mosi    = IdleByte;
    rv      = 1'b0;
    rb      = 8'd0;
    wt      = 1'b0;
    done    = 1'b0;
    st      = ST_OK;
    cs      = 1'b0;
    bi      = 3'd0;
    if (in_op[0] == 1'b0) bad = {1'b0, in_bn} >= {1'b0, total_q};
    else                  bad = (in_bc == 16'd0) || (end_blk > {1'b0, total_q});

    if (!in_cmd) begin
      if (phase_q != PH_IDLE) begin
        cs = 1'b1;
      end else if (bad) begin
        done = 1'b1;
        st   = ST_RANGE;
      end else begin
        oper_d  = in_op;
        left_d  = in_op[0] ? in_bc : 16'd1;
        addr_d  = new_addr;
        phase_d = PH_CMD;
        idx_d   = '0;
        poll_d  = '0;
        mosi    = frame_byte(op_cmd(in_op), new_addr, 3'd0);
        cs      = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_CMD, PH_SCMD: begin
          idx_d = idx_q + IdxW'(1);
          bi    = idx_d[2:0];
          if (idx_d < IdxW'(6)) begin
            mosi = (phase_q == PH_CMD) ? frame_byte(op_cmd(oper_q), addr_q, bi)
                                       : frame_byte(CmdStop, 32'd0, bi);
          end else begin
            idx_d   = '0;
            poll_d  = '0;
            phase_d = (phase_q == PH_CMD) ? PH_R1 : PH_SSTUFF;
          end
        end
        PH_R1: begin
          if (!m[7]) begin
            poll_d = '0;
            if (m != 8'd0) begin
              phase_d = PH_IDLE; done = 1'b1; st = ST_R1_ERROR;
            end else if (!oper_q[1]) begin
              phase_d = PH_RTOK;
            end else begin
              phase_d = PH_WTOK;
              mosi    = (oper_q == OP_WRITE_ONE) ? TokSingle : TokMulti;
            end
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_R1_TIMEOUT; end
          end
        end
        PH_RTOK: begin
          if (m == TokSingle) begin
            phase_d = PH_RDATA;
            idx_d   = '0;
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_TOKEN_TIMEOUT; end
          end
        end
        PH_RDATA: begin
          rv    = 1'b1;
          rb    = m;
          idx_d = idx_q + IdxW'(1);
          if (idx_q == IdxW'(BlockBytes - 1)) begin
            phase_d = PH_RCRC;
            idx_d   = '0;
          end
        end
        PH_RCRC: begin
          idx_d = idx_q + IdxW'(1);
          if (idx_q != '0) begin
            idx_d  = '0;
            poll_d = '0;
            left_d = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
            if (oper_q == OP_READ_ONE) phase_d = PH_RTRAIL;
            else if (left_d != 16'd0) phase_d = PH_RTOK;
            else begin
              phase_d = PH_SCMD;
              mosi    = frame_byte(CmdStop, 32'd0, 3'd0);
            end
          end
        end
        PH_RTRAIL: begin
          phase_d = PH_IDLE; done = 1'b1;
          st = (m == IdleByte) ? ST_OK : ST_TRAILER;
        end
        PH_SSTUFF: begin
          phase_d = PH_SR1;
          poll_d  = '0;
        end
        PH_SR1: begin
          if (!m[7]) begin
            phase_d = (m == 8'd0) ? PH_SBUSY_OK : PH_SBUSY_BAD;
            poll_d  = '0;
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_STOP_ERROR; end
          end
        end
        PH_SBUSY_OK, PH_SBUSY_BAD: begin
          if (m != 8'd0) begin
            phase_d = PH_IDLE; done = 1'b1;
            st = (phase_q == PH_SBUSY_OK) ? ST_OK : ST_STOP_ERROR;
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_BUSY_TIMEOUT; end
          end
        end
        PH_WTOK: begin
          phase_d = PH_WDATA;
          mosi    = w;
          wt      = 1'b1;
          idx_d   = IdxW'(1);
        end
        PH_WDATA: begin
          if (idx_q < IdxW'(BlockBytes)) begin
            mosi  = w;
            wt    = 1'b1;
            idx_d = idx_q + IdxW'(1);
          end else begin
            phase_d = PH_WCRC;
            idx_d   = '0;
          end
        end
        PH_WCRC: begin
          idx_d = idx_q + IdxW'(1);
          if (idx_q != '0) begin
            phase_d = PH_WRESP;
            idx_d   = '0;
            poll_d  = '0;
          end
        end
        PH_WRESP: begin
          if ((m & 8'h11) == 8'h01) begin
            if (m[3:1] == 3'd2) begin
              phase_d = PH_WBUSY;
              poll_d  = '0;
            end else begin
              phase_d = PH_IDLE; done = 1'b1;
              st = (m[3:1] == 3'd5) ? ST_CRC_REJECT : ST_WRITE_REJECT;
            end
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_RESP_TIMEOUT; end
          end
        end
        PH_WBUSY: begin
          if (m == IdleByte) begin
            poll_d = '0;
            left_d = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
            if (oper_q == OP_WRITE_ONE) begin
              phase_d = PH_IDLE; done = 1'b1;
            end else if (left_d == 16'd0) begin
              phase_d = PH_WSTOP;
              mosi    = TokStop;
            end else begin
              phase_d = PH_WTOK;
              mosi    = TokMulti;
            end
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_BUSY_TIMEOUT; end
          end
        end
        PH_WSTOP: begin
          phase_d = PH_WSTOPBUSY;
          poll_d  = '0;
        end
        PH_WSTOPBUSY: begin
          if (m == IdleByte) begin
            phase_d = PH_IDLE; done = 1'b1;
          end else begin
            poll_d = poll_inc;
            if (miss) begin phase_d = PH_IDLE; done = 1'b1; st = ST_BUSY_TIMEOUT; end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      cs = (phase_d != PH_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q    <= 1'b0;
      total_q <= '0;
      stok_q  <= PollW'(10000);
      mtok_q  <= PollW'(100000);
      bwait_q <= PollW'(100000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_CAP:     hc_q    <= cfg_data_i[0];
        CFG_TOTAL_BLOCKS: total_q <= cfg_data_i;
        CFG_SINGLE_TOK:   stok_q  <= cfg_data_i[PollW-1:0];
        CFG_MULTI_TOK:    mtok_q  <= cfg_data_i[PollW-1:0];
        CFG_BUSY_WAIT:    bwait_q <= cfg_data_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      idx_q       <= '0;
      poll_q      <= '0;
      left_q      <= '0;
      addr_q      <= '0;
      oper_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        poll_q  <= poll_d;
        left_q  <= left_d;
        addr_q  <= addr_d;
        oper_q  <= oper_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= {OutDataW'(0)} | OutDataW'({st, done, wt, rb, rv, cs, mosi});
    end
  end

endmodule
`default_nettype wire
